/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL of this project.
// Each macro takes a label and a property expression sampled on clock.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("assertion failed");
`define ASSERT_RST(lbl, prop) \
   lbl: assert property (@(posedge clock) (prop)) else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_RST(lbl, prop)
`endif
`endif

/* rtl/core/pies_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pies_pkg
// Types, codes and saturating helpers for the per-id event statistics block.
// ----------------------------------------------------------------------------
package pies_pkg;

   localparam int DEF_NUM_IDS       = 512;
   localparam int DEF_WINDOW_EPOCHS = 20;

   // Slot index and fill count cover windows of up to 31 epochs.
   localparam int SLOT_W = 5;
   // Window sums: 31 slots of 32-bit calls and 48-bit times.
   localparam int WSUM_W  = 37;
   localparam int WTIME_W = 53;
   localparam int DIV_N_W = WTIME_W;
   localparam int DIV_D_W = WSUM_W;

   localparam logic [2:0] MODE_BLOCKED = 3'd0;
   localparam logic [2:0] MODE_SWITCH  = 3'd1;
   localparam logic [2:0] MODE_ABORT   = 3'd2;
   localparam logic [2:0] MODE_TICK    = 3'd3;
   localparam logic [2:0] MODE_QUERY   = 3'd4;

   localparam logic [1:0] DIV_AVG  = 2'd0;
   localparam logic [1:0] DIV_MEAN = 2'd1;
   localparam logic [1:0] DIV_CTX  = 2'd2;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EV_RD,
      ST_EV_WR,
      ST_T_RD,
      ST_T_WR,
      ST_Q_RD,
      ST_Q_ENT,
      ST_Q_RRD,
      ST_Q_RACC,
      ST_Q_DSTART,
      ST_Q_DWAIT,
      ST_Q_FIN
   } state_type;

   typedef struct packed {
      logic              used;
      logic [31:0]       epoch_calls;
      logic [47:0]       epoch_time;
      logic [31:0]       last_calls;
      logic [31:0]       sum_calls;
      logic [31:0]       epoch_switches;
      logic [31:0]       sum_switches;
      logic [31:0]       max_switches;
      logic [31:0]       abort_count;
      logic [31:0]       max_delay;
      logic [21:0]       max_delay_pid;
      logic [31:0]       max_delay_uid;
      logic [SLOT_W-1:0] ring_head;
      logic [SLOT_W-1:0] ring_fill;
   } entry_type;

   typedef struct packed {
      logic [31:0] calls;
      logic [47:0] time_ns;
   } slot_type;

   function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [31:0] b);
      logic [48:0] s;
      s = {1'b0, a} + {17'd0, b};
      return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
   endfunction

endpackage

/* rtl/core/per_id_event_stats_with_epoch_window.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_id_event_stats_with_epoch_window
// Per-id statistics table with an epoch history ring and query divisions.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake            Carries
//  req_     in         req_valid/req_ready  mode, event_id, delay, pid, uid
//  rsp_     out        rsp_valid/rsp_ready  one result per query
//
// An event passes through accept, entry read, then modify and write back.
// An epoch tick walks the whole table, reading each entry and writing back the used ones.
// A query reads the entry, then reads and adds up each filled ring slot, then makes three
// passes of the one-bit-per-cycle shared divider (53 steps plus start and done).
// After reset a clearing pass zeroes every entry of the table.
// A waiting result sits in the output register; a later query stalls until it leaves.
module per_id_event_stats_with_epoch_window #(
   parameter int NUM_IDS       = pies_pkg::DEF_NUM_IDS,
   parameter int WINDOW_EPOCHS = pies_pkg::DEF_WINDOW_EPOCHS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_mode,
   input  logic [9:0]  req_event_id,
   input  logic [31:0] req_delay_ns,
   input  logic [21:0] req_task_pid,
   input  logic [31:0] req_task_uid,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_entry_valid,
   output logic [31:0] rsp_blocked_sum,
   output logic [31:0] rsp_prev_epoch_calls,
   output logic [31:0] rsp_avg_blocked_per_epoch,
   output logic [31:0] rsp_mean_delay_ns,
   output logic [31:0] rsp_max_delay_ns,
   output logic [31:0] rsp_abort_sum,
   output logic [31:0] rsp_avg_ctx_per_epoch,
   output logic [31:0] rsp_peak_ctx_per_epoch,
   output logic [21:0] rsp_peak_pid,
   output logic [31:0] rsp_peak_uid,
   output logic [31:0] rsp_epochs_elapsed
);
   import pies_pkg::*;

   `include "assert_macros.svh"

   localparam int IW         = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;
   localparam int RING_DEPTH = NUM_IDS * WINDOW_EPOCHS;
   localparam int RAW        = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

   state_type state_ff, state_in;

   // Latched request.
   logic [2:0]        mode_ff;
   logic              in_range_ff;
   logic [31:0]       delay_ff;
   logic [21:0]       pid_ff;
   logic [31:0]       uid_ff;
   logic [IW-1:0]     addr_ff;
   logic [31:0]       epoch_total_ff;

   // Table and ring memories.
   entry_type         ent_mem [NUM_IDS];
   entry_type         ent_q_ff;
   logic              ent_we;
   entry_type         ent_wdata;
   slot_type          ring_mem [RING_DEPTH];
   slot_type          ring_q_ff;
   logic              ring_we;
   logic [RAW-1:0]    ring_addr;
   logic [SLOT_W-1:0] ring_slot;

   // Query working registers.
   entry_type           q_ent_ff;
   logic [SLOT_W-1:0]   slot_ff;
   logic [SLOT_W-1:0]   cnt_ff;
   logic [WSUM_W-1:0]   wsum_ff;
   logic [WTIME_W-1:0]  wtime_ff;
   logic [1:0]          div_sel_ff;
   logic [31:0]         q_avg_ff;
   logic [31:0]         q_mean_ff;
   logic [31:0]         q_ctx_ff;
   logic [SLOT_W:0]     slot_start;

   // Shared divider.
   logic               div_start;
   logic               div_done;
   logic [DIV_N_W-1:0] div_dividend;
   logic [DIV_D_W-1:0] div_divisor;
   logic [DIV_N_W-1:0] div_quot;
   logic [31:0]        div_result;

   logic       rsp_valid_ff;
   logic       req_fire;
   logic       last_idx;
   entry_type  ev_ent;
   entry_type  tk_ent;

   assign req_fire = req_valid && req_ready;
   assign last_idx = (addr_ff == IW'(NUM_IDS - 1));

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:    if (last_idx) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_fire) begin
               case (req_mode)
                  MODE_BLOCKED, MODE_SWITCH, MODE_ABORT: begin
                     if ({1'b0, req_event_id} < 11'(NUM_IDS)) state_in = ST_EV_RD;
                  end
                  MODE_TICK:  state_in = ST_T_RD;
                  MODE_QUERY: state_in = ST_Q_RD;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_EV_RD:    state_in = ST_EV_WR;
         ST_EV_WR:    state_in = ST_IDLE;
         ST_T_RD:     state_in = ST_T_WR;
         ST_T_WR:     state_in = last_idx ? ST_IDLE : ST_T_RD;
         ST_Q_RD:     state_in = ST_Q_ENT;
         ST_Q_ENT:    state_in = ST_Q_RRD;
         ST_Q_RRD:    state_in = (cnt_ff == q_ent_ff.ring_fill) ? ST_Q_DSTART : ST_Q_RACC;
         ST_Q_RACC:   state_in = ST_Q_RRD;
         ST_Q_DSTART: state_in = ST_Q_DWAIT;
         ST_Q_DWAIT: begin
            if (div_done) state_in = (div_sel_ff == DIV_CTX) ? ST_Q_FIN : ST_Q_DSTART;
         end
         ST_Q_FIN:    if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Entry update for a blocked, switch or abort event.
   always_comb begin
      ev_ent      = ent_q_ff;
      ev_ent.used = 1'b1;
      case (mode_ff)
         MODE_BLOCKED: begin
            ev_ent.epoch_calls = sat_add32(ent_q_ff.epoch_calls, 32'd1);
            ev_ent.epoch_time  = sat_add48(ent_q_ff.epoch_time, delay_ff);
            if (delay_ff > ent_q_ff.max_delay) begin
               ev_ent.max_delay     = delay_ff;
               ev_ent.max_delay_pid = pid_ff;
               ev_ent.max_delay_uid = uid_ff;
            end
         end
         MODE_SWITCH: ev_ent.epoch_switches = sat_add32(ent_q_ff.epoch_switches, 32'd1);
         default:     ev_ent.abort_count = sat_add32(ent_q_ff.abort_count, 32'd1);
      endcase
   end

   // Entry update when an epoch closes.
   always_comb begin
      tk_ent                = ent_q_ff;
      tk_ent.last_calls     = ent_q_ff.epoch_calls;
      tk_ent.sum_calls      = sat_add32(ent_q_ff.sum_calls, ent_q_ff.epoch_calls);
      tk_ent.sum_switches   = sat_add32(ent_q_ff.sum_switches, ent_q_ff.epoch_switches);
      if (ent_q_ff.epoch_switches > ent_q_ff.max_switches)
         tk_ent.max_switches = ent_q_ff.epoch_switches;
      tk_ent.ring_head      = (ent_q_ff.ring_head == SLOT_W'(WINDOW_EPOCHS - 1)) ? '0
                              : ent_q_ff.ring_head + 1'b1;
      if (ent_q_ff.ring_fill < SLOT_W'(WINDOW_EPOCHS))
         tk_ent.ring_fill = ent_q_ff.ring_fill + 1'b1;
      tk_ent.epoch_calls    = '0;
      tk_ent.epoch_time     = '0;
      tk_ent.epoch_switches = '0;
   end

   // Oldest filled slot of the window.
   always_comb begin
      slot_start = {1'b0, ent_q_ff.ring_head} + (SLOT_W + 1)'(WINDOW_EPOCHS)
                   - {1'b0, ent_q_ff.ring_fill};
      if (slot_start >= (SLOT_W + 1)'(WINDOW_EPOCHS))
         slot_start = slot_start - (SLOT_W + 1)'(WINDOW_EPOCHS);
   end

   // Divider operand selection.
   always_comb begin
      case (div_sel_ff)
         DIV_AVG: begin
            div_dividend = DIV_N_W'(wsum_ff);
            div_divisor  = DIV_D_W'(q_ent_ff.ring_fill);
         end
         DIV_MEAN: begin
            div_dividend = wtime_ff;
            div_divisor  = wsum_ff;
         end
         default: begin
            div_dividend = DIV_N_W'(q_ent_ff.sum_switches);
            div_divisor  = DIV_D_W'(epoch_total_ff);
         end
      endcase
      if (div_divisor == '0)
         div_result = '0;
      else if (div_quot[DIV_N_W-1:32] != '0)
         div_result = 32'hFFFF_FFFF;
      else
         div_result = div_quot[31:0];
   end

   // Outputs of the sequencer.
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      ent_we    = 1'b0;
      ent_wdata = ev_ent;
      ring_we   = 1'b0;
      ring_slot = slot_ff;
      div_start = (state_ff == ST_Q_DSTART);
      case (state_ff)
         ST_CLEAR: begin
            ent_we    = 1'b1;
            ent_wdata = '0;
         end
         ST_EV_WR: ent_we = 1'b1;
         ST_T_WR: begin
            ent_we    = ent_q_ff.used;
            ent_wdata = tk_ent;
            ring_we   = ent_q_ff.used;
            ring_slot = ent_q_ff.ring_head;
         end
         default: ;
      endcase
      ring_addr = RAW'(addr_ff) * RAW'(WINDOW_EPOCHS) + RAW'(ring_slot);
   end

   // Memories with registered read data.
   always_ff @(posedge clock) begin
      if (ent_we) ent_mem[addr_ff] <= ent_wdata;
      ent_q_ff <= ent_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (ring_we) ring_mem[ring_addr] <= '{calls: ent_q_ff.epoch_calls,
                                           time_ns: ent_q_ff.epoch_time};
      ring_q_ff <= ring_mem[ring_addr];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         addr_ff        <= '0;
         epoch_total_ff <= '0;
         rsp_valid_ff   <= 1'b0;
         div_sel_ff     <= DIV_AVG;
      end else begin
         state_ff <= state_in;
         // A finishing query refills the output as the old result leaves.
         if (state_ff == ST_Q_FIN && (!rsp_valid_ff || rsp_ready))
            rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_ready)
            rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_CLEAR: addr_ff <= addr_ff + 1'b1;
            ST_IDLE: begin
               if (req_fire) begin
                  addr_ff <= (req_mode == MODE_TICK) ? '0 : req_event_id[IW-1:0];
                  if (req_mode == MODE_TICK)
                     epoch_total_ff <= sat_add32(epoch_total_ff, 32'd1);
               end
               div_sel_ff <= DIV_AVG;
            end
            ST_T_WR: addr_ff <= addr_ff + 1'b1;
            ST_Q_DWAIT: if (div_done) div_sel_ff <= div_sel_ff + 1'b1;
            default: ;
         endcase
      end
   end

   // Request and query datapath.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         mode_ff     <= req_mode;
         in_range_ff <= ({1'b0, req_event_id} < 11'(NUM_IDS));
         delay_ff    <= req_delay_ns;
         pid_ff      <= req_task_pid;
         uid_ff      <= req_task_uid;
      end
      case (state_ff)
         ST_Q_ENT: begin
            q_ent_ff <= in_range_ff ? ent_q_ff : '0;
            slot_ff  <= in_range_ff ? slot_start[SLOT_W-1:0] : '0;
            cnt_ff   <= '0;
            wsum_ff  <= '0;
            wtime_ff <= '0;
         end
         ST_Q_RACC: begin
            wsum_ff  <= wsum_ff + WSUM_W'(ring_q_ff.calls);
            wtime_ff <= wtime_ff + WTIME_W'(ring_q_ff.time_ns);
            cnt_ff   <= cnt_ff + 1'b1;
            slot_ff  <= (slot_ff == SLOT_W'(WINDOW_EPOCHS - 1)) ? '0 : slot_ff + 1'b1;
         end
         ST_Q_DWAIT: begin
            if (div_done) begin
               case (div_sel_ff)
                  DIV_AVG:  q_avg_ff  <= div_result;
                  DIV_MEAN: q_mean_ff <= div_result;
                  default:  q_ctx_ff  <= div_result;
               endcase
            end
         end
         default: ;
      endcase
   end

   // Output register: loaded as the query finishes.
   always_ff @(posedge clock) begin
      if (state_ff == ST_Q_FIN && (!rsp_valid_ff || rsp_ready)) begin
         rsp_entry_valid           <= q_ent_ff.used;
         rsp_blocked_sum           <= q_ent_ff.sum_calls;
         rsp_prev_epoch_calls      <= q_ent_ff.last_calls;
         rsp_avg_blocked_per_epoch <= q_avg_ff;
         rsp_mean_delay_ns         <= q_mean_ff;
         rsp_max_delay_ns          <= q_ent_ff.max_delay;
         rsp_abort_sum             <= q_ent_ff.abort_count;
         rsp_avg_ctx_per_epoch     <= q_ctx_ff;
         rsp_peak_ctx_per_epoch    <= q_ent_ff.max_switches;
         rsp_peak_pid              <= q_ent_ff.max_delay_pid;
         rsp_peak_uid              <= q_ent_ff.max_delay_uid;
         rsp_epochs_elapsed        <= epoch_total_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   pies_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   // The clearing pass never produces a result.
   `ASSERT_CLK(a_no_rsp_in_clear, (state_ff == ST_CLEAR) |-> !rsp_valid_ff)
   // A new result only appears after the final query step.
   `ASSERT_CLK(a_rsp_from_fin, $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_Q_FIN))
   // The window walk never passes the filled slot count.
   `ASSERT_CLK(a_walk_bound, (state_ff == ST_Q_RRD) |-> (cnt_ff <= q_ent_ff.ring_fill))
   // The divider never signals done in the cycle after a start.
   `ASSERT_CLK(a_div_latency, div_start |=> !div_done)

endmodule

/* rtl/core/pies_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pies_div
// Restoring divider, one quotient bit per cycle, shared by all query ratios.
// ----------------------------------------------------------------------------
module pies_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [pies_pkg::DIV_N_W-1:0]   dividend,
   input  logic [pies_pkg::DIV_D_W-1:0]   divisor,
   output logic                           done,
   output logic [pies_pkg::DIV_N_W-1:0]   quotient
);
   import pies_pkg::*;

   localparam int CNT_W = $clog2(DIV_N_W);

   logic               busy_ff;
   logic               done_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [DIV_D_W-1:0] rem_ff;
   logic [DIV_D_W-1:0] div_ff;
   logic [DIV_N_W-1:0] quo_ff;
   logic [DIV_D_W:0]   trial;
   logic [DIV_D_W:0]   diff;
   logic               take;

   // One trial subtraction per step.
   always_comb begin
      trial = {rem_ff, quo_ff[DIV_N_W-1]};
      diff  = trial - {1'b0, div_ff};
      take  = (trial >= {1'b0, div_ff});
   end

   // Control: busy for one step per quotient bit, done pulses at the end.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_N_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath: partial remainder and dividend shifting into the quotient.
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         div_ff <= divisor;
         quo_ff <= dividend;
      end else if (busy_ff) begin
         rem_ff <= take ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
         quo_ff <= {quo_ff[DIV_N_W-2:0], take};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* verif/per_id_event_stats_with_epoch_window_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_id_event_stats_with_epoch_window_checker
// Watches the request and response channels of the statistics block. It keeps
// its own copy of the per-id table and the epoch ring, works out the answer
// to each query when the query is taken, and compares every response transfer
// field by field against the oldest waiting answer.
// ----------------------------------------------------------------------------
module per_id_event_stats_with_epoch_window_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [2:0]  req_mode,
   input  logic [9:0]  req_event_id,
   input  logic [31:0] req_delay_ns,
   input  logic [21:0] req_task_pid,
   input  logic [31:0] req_task_uid,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_entry_valid,
   input  logic [31:0] rsp_blocked_sum,
   input  logic [31:0] rsp_prev_epoch_calls,
   input  logic [31:0] rsp_avg_blocked_per_epoch,
   input  logic [31:0] rsp_mean_delay_ns,
   input  logic [31:0] rsp_max_delay_ns,
   input  logic [31:0] rsp_abort_sum,
   input  logic [31:0] rsp_avg_ctx_per_epoch,
   input  logic [31:0] rsp_peak_ctx_per_epoch,
   input  logic [21:0] rsp_peak_pid,
   input  logic [31:0] rsp_peak_uid,
   input  logic [31:0] rsp_epochs_elapsed,
   output int          fail_count,
   output int          answers_pending,
   output int          answers_checked
);
   import pies_pkg::*;

   localparam int IDS = DEF_NUM_IDS;
   localparam int WIN = DEF_WINDOW_EPOCHS;

   typedef struct packed {
      logic        entry_valid;
      logic [31:0] blocked_sum;
      logic [31:0] prev_calls;
      logic [31:0] avg_blocked;
      logic [31:0] mean_delay;
      logic [31:0] peak_delay;
      logic [31:0] abort_sum;
      logic [31:0] avg_ctx;
      logic [31:0] peak_ctx;
      logic [21:0] peak_pid;
      logic [31:0] peak_uid;
      logic [31:0] epochs;
   } stats_answer_type;

   // Model copy of the statistics table.
   logic        used_q      [IDS];
   logic [31:0] open_calls  [IDS];
   logic [47:0] open_time   [IDS];
   logic [31:0] last_calls  [IDS];
   logic [31:0] total_calls [IDS];
   logic [31:0] open_sw     [IDS];
   logic [31:0] total_sw    [IDS];
   logic [31:0] peak_sw     [IDS];
   logic [31:0] aborts      [IDS];
   logic [31:0] peak_delay  [IDS];
   logic [21:0] peak_pid    [IDS];
   logic [31:0] peak_uid    [IDS];
   logic [31:0] hist_calls  [IDS][WIN];
   logic [47:0] hist_time   [IDS][WIN];
   int          hist_head   [IDS];
   int          hist_fill   [IDS];
   logic [31:0] epochs_seen;

   stats_answer_type answer_queue[$];
   int               mismatches;

   assign fail_count      = mismatches;
   assign answers_pending = answer_queue.size();

   function automatic logic [31:0] add_sat32(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic logic [47:0] add_sat48(logic [47:0] a, logic [31:0] b);
      logic [48:0] s;
      s = {1'b0, a} + {17'd0, b};
      return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
   endfunction

   // Close the open epoch of one entry and push it into its history ring.
   function automatic void close_entry_epoch(int id);
      int h;
      h = hist_head[id];
      last_calls[id]  = open_calls[id];
      total_calls[id] = add_sat32(total_calls[id], open_calls[id]);
      total_sw[id]    = add_sat32(total_sw[id], open_sw[id]);
      if (open_sw[id] > peak_sw[id])
         peak_sw[id] = open_sw[id];
      hist_calls[id][h] = open_calls[id];
      hist_time[id][h]  = open_time[id];
      hist_head[id]     = (h + 1) % WIN;
      if (hist_fill[id] < WIN)
         hist_fill[id]++;
      open_calls[id] = '0;
      open_time[id]  = '0;
      open_sw[id]    = '0;
   endfunction

   // Work out the statistics answer for one id.
   function automatic stats_answer_type stats_for_id(int id);
      stats_answer_type a;
      logic [63:0]      wsum;
      logic [63:0]      wtime;
      logic [63:0]      mean;
      int               k;
      a = '0;
      a.epochs = epochs_seen;
      if (id >= IDS)
         return a;
      wsum  = '0;
      wtime = '0;
      for (int i = 0; i < hist_fill[id]; i++) begin
         k = (hist_head[id] + WIN - hist_fill[id] + i) % WIN;
         wsum  += hist_calls[id][k];
         wtime += hist_time[id][k];
      end
      mean = (wsum != 0) ? wtime / wsum : 64'd0;
      if (mean > 64'hFFFF_FFFF)
         mean = 64'hFFFF_FFFF;
      a.entry_valid = used_q[id];
      a.blocked_sum = total_calls[id];
      a.prev_calls  = last_calls[id];
      a.avg_blocked = (hist_fill[id] != 0) ? 32'(wsum / hist_fill[id]) : 32'd0;
      a.mean_delay  = mean[31:0];
      a.peak_delay  = peak_delay[id];
      a.abort_sum   = aborts[id];
      a.avg_ctx     = (epochs_seen != 0) ? total_sw[id] / epochs_seen : 32'd0;
      a.peak_ctx    = peak_sw[id];
      a.peak_pid    = peak_pid[id];
      a.peak_uid    = peak_uid[id];
      return a;
   endfunction

   task automatic show_field(string name, logic [63:0] e, logic [63:0] a);
      if (e != a)
         $display("  %s: expected %0d, got %0d", name, e, a);
   endtask

   // Compare one response transfer with the oldest waiting answer.
   task automatic check_answer();
      stats_answer_type got;
      stats_answer_type want;
      got = '{rsp_entry_valid, rsp_blocked_sum, rsp_prev_epoch_calls,
              rsp_avg_blocked_per_epoch, rsp_mean_delay_ns, rsp_max_delay_ns,
              rsp_abort_sum, rsp_avg_ctx_per_epoch, rsp_peak_ctx_per_epoch,
              rsp_peak_pid, rsp_peak_uid, rsp_epochs_elapsed};
      if (answer_queue.size() == 0) begin
         if (mismatches < 10)
            $display("ERROR %0t: response transfer with no query waiting", $realtime);
         mismatches++;
         return;
      end
      want = answer_queue.pop_front();
      answers_checked++;
      if (got != want) begin
         if (mismatches < 10) begin
            $display("ERROR %0t: response %0d differs", $realtime, answers_checked);
            show_field("entry_valid", want.entry_valid, got.entry_valid);
            show_field("blocked_sum", want.blocked_sum, got.blocked_sum);
            show_field("prev_epoch_calls", want.prev_calls, got.prev_calls);
            show_field("avg_blocked_per_epoch", want.avg_blocked, got.avg_blocked);
            show_field("mean_delay_ns", want.mean_delay, got.mean_delay);
            show_field("max_delay_ns", want.peak_delay, got.peak_delay);
            show_field("abort_sum", want.abort_sum, got.abort_sum);
            show_field("avg_ctx_per_epoch", want.avg_ctx, got.avg_ctx);
            show_field("peak_ctx_per_epoch", want.peak_ctx, got.peak_ctx);
            show_field("peak_pid", want.peak_pid, got.peak_pid);
            show_field("peak_uid", want.peak_uid, got.peak_uid);
            show_field("epochs_elapsed", want.epochs, got.epochs);
         end
         mismatches++;
      end
   endtask

   // Apply one request transfer to the model table.
   task automatic apply_request();
      int id;
      id = req_event_id;
      case (req_mode)
         MODE_BLOCKED: if (id < IDS) begin
            used_q[id]     = 1'b1;
            open_calls[id] = add_sat32(open_calls[id], 32'd1);
            open_time[id]  = add_sat48(open_time[id], req_delay_ns);
            // A delay equal to the peak keeps the earlier owner.
            if (req_delay_ns > peak_delay[id]) begin
               peak_delay[id] = req_delay_ns;
               peak_pid[id]   = req_task_pid;
               peak_uid[id]   = req_task_uid;
            end
         end
         MODE_SWITCH: if (id < IDS) begin
            used_q[id]  = 1'b1;
            open_sw[id] = add_sat32(open_sw[id], 32'd1);
         end
         MODE_ABORT: if (id < IDS) begin
            used_q[id] = 1'b1;
            aborts[id] = add_sat32(aborts[id], 32'd1);
         end
         MODE_TICK: begin
            epochs_seen = add_sat32(epochs_seen, 32'd1);
            for (int i = 0; i < IDS; i++)
               if (used_q[i])
                  close_entry_epoch(i);
         end
         MODE_QUERY: answer_queue.push_back(stats_for_id(id));
         default: ;
      endcase
   endtask

   // Track both channels; responses are checked before the same edge's request.
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < IDS; i++) begin
            used_q[i] = 0; open_calls[i] = 0; open_time[i] = 0; last_calls[i] = 0;
            total_calls[i] = 0; open_sw[i] = 0; total_sw[i] = 0; peak_sw[i] = 0;
            aborts[i] = 0; peak_delay[i] = 0; peak_pid[i] = 0; peak_uid[i] = 0;
            hist_head[i] = 0; hist_fill[i] = 0;
            for (int j = 0; j < WIN; j++) begin
               hist_calls[i][j] = 0;
               hist_time[i][j]  = 0;
            end
         end
         epochs_seen     = 0;
         mismatches      = 0;
         answers_checked = 0;
         answer_queue.delete();
      end else begin
         if (rsp_valid && rsp_ready)
            check_answer();
         if (req_valid && req_ready)
            apply_request();
      end
   end

endmodule

/* verif/per_id_event_stats_with_epoch_window_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_id_event_stats_with_epoch_window_test
// Drives events, epoch ticks and queries into the statistics block: a short
// directed opening on the corner cases, then a random mix focused on a few
// ids so that their history rings wrap. Both channels idle at random, and the
// receiver once holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module per_id_event_stats_with_epoch_window_test;
   import pies_pkg::*;

   localparam int RANDOM_ITEMS = 1530;
   localparam int IDLE_LIMIT   = 20000;
   localparam int DRAIN_CYCLES = 2200;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_mode;
   logic [9:0]  req_event_id;
   logic [31:0] req_delay_ns;
   logic [21:0] req_task_pid;
   logic [31:0] req_task_uid;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_entry_valid;
   logic [31:0] rsp_blocked_sum;
   logic [31:0] rsp_prev_epoch_calls;
   logic [31:0] rsp_avg_blocked_per_epoch;
   logic [31:0] rsp_mean_delay_ns;
   logic [31:0] rsp_max_delay_ns;
   logic [31:0] rsp_abort_sum;
   logic [31:0] rsp_avg_ctx_per_epoch;
   logic [31:0] rsp_peak_ctx_per_epoch;
   logic [21:0] rsp_peak_pid;
   logic [31:0] rsp_peak_uid;
   logic [31:0] rsp_epochs_elapsed;
   int          fail_count;
   int          answers_pending;
   int          answers_checked;
   int          items_sent;
   int          ticks_sent;
   int          idle_cycles;
   bit          hold_off_done;

   per_id_event_stats_with_epoch_window dut (.*);
   per_id_event_stats_with_epoch_window_checker stats_checker (.*);

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Offer one request and hold it until the transfer completes.
   task automatic send_item(logic [2:0] mode, logic [9:0] id, logic [31:0] delay,
                            logic [21:0] pid, logic [31:0] uid);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_mode     <= mode;
      req_event_id <= id;
      req_delay_ns <= delay;
      req_task_pid <= pid;
      req_task_uid <= uid;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (mode == MODE_TICK)
         ticks_sent++;
   endtask

   // Random request: most traffic goes to a handful of ids.
   task automatic send_random_item();
      int          r;
      logic [2:0]  mode;
      logic [9:0]  id;
      logic [31:0] delay;
      r = $urandom_range(0, 99);
      if (r < 38)      mode = MODE_BLOCKED;
      else if (r < 53) mode = MODE_SWITCH;
      else if (r < 62) mode = MODE_ABORT;
      else if (r < 66) mode = MODE_TICK;
      else if (r < 97) mode = MODE_QUERY;
      else             mode = 3'($urandom_range(5, 7));
      r = $urandom_range(0, 99);
      if (r < 70)      id = 10'($urandom_range(0, 7));
      else if (r < 80) id = 10'($urandom_range(DEF_NUM_IDS - 4, DEF_NUM_IDS - 1));
      else if (r < 90) id = 10'($urandom_range(DEF_NUM_IDS, 1023));
      else             id = 10'($urandom);
      r = $urandom_range(0, 9);
      if (r < 4)       delay = $urandom_range(0, 1000);
      else if (r == 4) delay = 32'hFFFF_FFFF;
      else             delay = $urandom;
      send_item(mode, id, delay, 22'($urandom), $urandom);
   endtask

   // Receiver: random stalls, plus one long hold-off midway through the run.
   initial begin
      int gap;
      rsp_ready     = 1'b0;
      hold_off_done = 1'b0;
      @(posedge clock iff !reset);
      forever begin
         if (!hold_off_done && items_sent > 700) begin
            hold_off_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (1500) @(posedge clock);
         end
         gap = pick_gap();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   // Watchdog on cycles with no transfer on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
         $display("simulation failed");
         $finish;
      end
   end

   // Stimulus and verdict.
   initial begin
      int settle;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_mode     = MODE_BLOCKED;
      req_event_id = '0;
      req_delay_ns = '0;
      req_task_pid = '0;
      req_task_uid = '0;
      items_sent   = 0;
      ticks_sent   = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed opening: unused and out-of-range ids, extremes, equal peak.
      send_item(MODE_QUERY, 10'd0, '0, '0, '0);
      send_item(MODE_QUERY, 10'd1023, '0, '0, '0);
      send_item(MODE_QUERY, 10'd512, '0, '0, '0);
      send_item(MODE_BLOCKED, 10'd0, 32'd0, 22'h3FFFFF, 32'hFFFF_FFFF);
      send_item(MODE_QUERY, 10'd0, '0, '0, '0);
      send_item(MODE_BLOCKED, 10'd0, 32'hFFFF_FFFF, 22'h3FFFFF, 32'hFFFF_FFFF);
      send_item(MODE_BLOCKED, 10'd0, 32'hFFFF_FFFF, 22'd1, 32'd1);
      send_item(MODE_SWITCH, 10'd0, '0, '0, '0);
      send_item(MODE_SWITCH, 10'd511, '0, '0, '0);
      send_item(MODE_ABORT, 10'd0, '0, '0, '0);
      send_item(MODE_ABORT, 10'd600, '0, '0, '0);
      send_item(MODE_BLOCKED, 10'd1023, 32'd77, 22'd5, 32'd6);
      send_item(MODE_SWITCH, 10'd512, '0, '0, '0);
      send_item(3'd5, 10'd0, 32'hFFFF_FFFF, 22'h3FFFFF, 32'hFFFF_FFFF);
      send_item(3'd6, 10'd1, '0, '0, '0);
      send_item(3'd7, 10'd2, '0, '0, '0);
      send_item(MODE_QUERY, 10'd0, '0, '0, '0);
      send_item(MODE_TICK, 10'd0, '0, '0, '0);
      send_item(MODE_QUERY, 10'd0, '0, '0, '0);
      send_item(MODE_QUERY, 10'd511, '0, '0, '0);
      send_item(MODE_BLOCKED, 10'd511, 32'd1, 22'h2AAAAA, 32'h5555_5555);
      send_item(MODE_TICK, 10'd1023, '0, '0, '0);
      send_item(MODE_QUERY, 10'd511, '0, '0, '0);
      send_item(MODE_QUERY, 10'd1, '0, '0, '0);

      repeat (RANDOM_ITEMS) send_random_item();
      req_valid <= 1'b0;

      // Drain the remaining answers, then let any tick in flight finish.
      while (answers_pending != 0) @(posedge clock);
      for (settle = 0; settle < DRAIN_CYCLES; settle++) @(posedge clock);

      $display("Run: %0d requests, %0d epoch ticks, %0d query responses checked.",
               items_sent, ticks_sent, answers_checked);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("simulation failed");
      end
      $finish;
   end

endmodule

/* per_id_event_stats_with_epoch_window.f */
+incdir+rtl/core
rtl/core/pies_pkg.sv
rtl/core/pies_div.sv
rtl/core/per_id_event_stats_with_epoch_window.sv
verif/per_id_event_stats_with_epoch_window_checker.sv
verif/per_id_event_stats_with_epoch_window_test.sv
